// ----- rtl/url_percent_decoder_unit_assert.svh -----
// Assertion macros for the URL percent decoder.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef URL_PERCENT_DECODER_UNIT_ASSERT_SVH
`define URL_PERCENT_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked at every rising edge outside reset.
`define URLDEC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("URL decoder assertion failed");
// Checked at every rising edge, reset included.
`define URLDEC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("URL decoder assertion failed");
`else
`define URLDEC_ASSERT(label, clk, rst, prop)
`define URLDEC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- rtl/urldec_pkg.sv -----
// Shared types, constants and the hex digit decode for the URL percent decoder.
// No dependencies.
package urldec_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam int         QUEUE_DEPTH = 3;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PCT      = 2'd1,
    PH_PCT_CHAR = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Value of an ASCII hex digit; ok is low for any other byte.
  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok = 1'b1;
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.ok  = 1'b1;
      h.val = 4'(c[3:0] + 4'd9);
    end
    return h;
  endfunction

endpackage

// ----- rtl/urldec_in_if.sv -----
// Input channel of the URL percent decoder: one raw byte per item.
// Stand-alone; no package needed.
interface urldec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- rtl/urldec_out_if.sv -----
// Output channel of the URL percent decoder: one decoded byte per item.
// Stand-alone; no package needed.
interface urldec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- rtl/url_percent_decoder_unit.sv -----
// Top level of the streaming URL percent decoder.
// Depends on urldec_pkg, urldec_in_if, urldec_out_if and the assertion macro header.
//
//   channel  direction  item carries
//   -------  ---------  ---------------------------------------------
//   rx       in         in_byte (8 bits), in_last (1 bit)
//   tx       out        out_byte (8 bits), out_last (1 bit)
//
// An accepted item is decoded in the same cycle and its zero, one or two results are
// written into a three-entry result queue; the queue head drives tx directly.
// Sustained rate is one item per clock while tx takes results every cycle. An item
// that yields two results (a trailing '%' plus one character) leaves two results queued
// and so holds off the next item, since rx is ready only while the queue holds at most one result.
// rst is synchronous and active high; it empties the queue and returns to idle.
// A stall on tx fills the queue and then drops rx.ready; nothing is lost.
`include "url_percent_decoder_unit_assert.svh"

module url_percent_decoder_unit
  import urldec_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  urldec_in_if.sink           rx,
  urldec_out_if.source        tx
);

  // Decoder state.
  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held_char;
  logic [7:0] held_char_next;

  // Result queue, head at entry 0.
  result_t    queue [QUEUE_DEPTH];
  result_t    queue_next [QUEUE_DEPTH];
  logic [1:0] count;
  logic [1:0] count_next;

  // Results of the item on rx this cycle.
  logic [1:0] n_res;
  result_t    res0;
  result_t    res1;
  hex_t       d1;
  hex_t       d2;

  logic       accept;
  logic       pop;
  logic [1:0] base;

  // Accepting only with at most one result queued leaves room for two more.
  assign rx.ready = (count <= 2'd1);
  assign accept   = rx.valid && rx.ready;

  assign tx.valid    = (count != 2'd0);
  assign tx.out_byte = queue[0].data;
  assign tx.out_last = queue[0].last;
  assign pop         = tx.valid && tx.ready;

  assign d1 = hex_digit(held_char);
  assign d2 = hex_digit(rx.in_byte);

  // Next phase and the results an accepted item produces.
  always_comb begin
    phase_next     = phase;
    held_char_next = held_char;
    n_res          = 2'd0;
    res0.data      = rx.in_byte;
    res0.last      = rx.in_last;
    res1.data      = rx.in_byte;
    res1.last      = 1'b1;
    case (phase)
      PH_PCT: begin
        if (rx.in_byte == PCT_CHAR) begin
          // "%%" collapses to one percent sign.
          phase_next = PH_IDLE;
          n_res      = 2'd1;
          res0.data  = PCT_CHAR;
        end else begin
          held_char_next = rx.in_byte;
          if (rx.in_last) begin
            // A string that ends in '%' and one character is sent on literally.
            phase_next = PH_IDLE;
            n_res      = 2'd2;
            res0.data  = PCT_CHAR;
            res0.last  = 1'b0;
          end else begin
            phase_next = PH_PCT_CHAR;
          end
        end
      end
      PH_PCT_CHAR: begin
        // The value comes from the leading hex digits only.
        phase_next = PH_IDLE;
        n_res      = 2'd1;
        if (!d1.ok) begin
          res0.data = 8'h00;
        end else if (!d2.ok) begin
          res0.data = {4'h0, d1.val};
        end else begin
          res0.data = {d1.val, d2.val};
        end
      end
      default: begin
        // Idle, and the unused phase code, which behaves as idle.
        phase_next = PH_IDLE;
        if (rx.in_byte == PCT_CHAR && !rx.in_last) begin
          phase_next = PH_PCT;
        end else begin
          n_res = 2'd1;
        end
      end
    endcase
    if (!accept) begin
      phase_next     = phase;
      held_char_next = held_char;
      n_res          = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      held_char <= 8'h00;
    end else begin
      phase     <= phase_next;
      held_char <= held_char_next;
    end
  end

  // Queue update: shift out the head on a pop, then append the new results behind
  // whatever remains.
  always_comb begin
    base = count - {1'b0, pop};
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_next[i] = queue[i];
    end
    if (pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        queue_next[i] = queue[i + 1];
      end
    end
    case (base)
      2'd0: begin
        if (n_res != 2'd0) queue_next[0] = res0;
        if (n_res == 2'd2) queue_next[1] = res1;
      end
      2'd1: begin
        if (n_res != 2'd0) queue_next[1] = res0;
        if (n_res == 2'd2) queue_next[2] = res1;
      end
      default: begin
        // No item is accepted with two or more results left queued.
      end
    endcase
    count_next = base + n_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue[i] <= queue_next[i];
    end
  end

  // The end of a string always leaves the decoder idle.
  `URLDEC_ASSERT(a_last_to_idle, clk, rst, accept && rx.in_last |=> phase == PH_IDLE)
  // An item that ends a string queues at least one result.
  `URLDEC_ASSERT(a_last_gives_result, clk, rst,
    accept && rx.in_last && !pop |=> count != 2'd0)
  // Completing an escape queues exactly one byte.
  `URLDEC_ASSERT(a_escape_one_byte, clk, rst,
    accept && phase == PH_PCT_CHAR && !pop |=> count == $past(count) + 2'd1)

endmodule
